[hw/rtl/head_pose_to_screen_offset_macros.svh]
// Assertion macros used by the checker file of the head pose block.
// No dependencies.
`ifndef HEAD_POSE_TO_SCREEN_OFFSET_MACROS_SVH
`define HEAD_POSE_TO_SCREEN_OFFSET_MACROS_SVH

// same-cycle implication, disabled during reset
`define HPS_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("head pose assertion failed");

// next-cycle implication, disabled during reset
`define HPS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("head pose assertion failed");

`endif

[hw/rtl/hps_pkg.sv]
// Package for the head pose to screen offset block: codes, types, rounding.
// No dependencies.
package hps_pkg;

  localparam int MulW  = 26;
  localparam int ProdW = 2 * MulW;
  localparam int AccW  = 64;
  localparam int NumW  = 58;
  localparam int DenW  = 40;
  localparam int QuoW  = 16;
  localparam int CfgW  = 20;
  localparam int CfgIdxW = 3;

  localparam logic signed [AccW-1:0] DepthFloor = 64'sd268435;
  localparam logic [16:0] AlphaOne = 17'd65536;

  typedef enum logic [1:0] {
    FUNC_VALID   = 2'd0,
    FUNC_INVALID = 2'd1,
    FUNC_DISABLE = 2'd2,
    FUNC_RECENTER = 2'd3
  } func_e;

  typedef enum logic [CfgIdxW-1:0] {
    REG_INV_HTAN  = 3'd0,
    REG_INV_VTAN  = 3'd1,
    REG_MOVE_LIM  = 3'd2,
    REG_DEAD_BAND = 3'd3,
    REG_ALPHA     = 3'd4,
    REG_MAX_STEP  = 3'd5,
    REG_HALF_W    = 3'd6,
    REG_HALF_H    = 3'd7
  } reg_idx_e;

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_MAC  = 4'b0010,
    ST_DIV  = 4'b0100,
    ST_OUT  = 4'b1000
  } state_e;

  typedef enum logic [3:0] {
    PH_RX, PH_RY, PH_RZ, PH_RW, PH_VX, PH_VY, PH_DP, PH_NUM, PH_TGT, PH_FLT
  } phase_e;

  // multiplier side-band: accumulate command that travels with the product
  typedef struct packed {
    logic vld;
    logic clr;
    logic neg;
    logic sh;
  } mul_ctl_t;

  // number of products summed in a phase
  function automatic logic [2:0] ph_muls(input phase_e ph);
    logic [2:0] k;
    case (ph)
      PH_VX, PH_VY, PH_NUM: k = 3'd2;
      PH_TGT, PH_FLT:       k = 3'd1;
      default:              k = 3'd4;
    endcase
    return k;
  endfunction

  // v / 2^s rounded to nearest, ties away from zero
  function automatic logic signed [AccW-1:0] rnd_shr(input logic signed [AccW-1:0] v,
                                                      input int unsigned s);
    logic [AccW-1:0] mag;
    logic [AccW-1:0] half;
    logic [AccW-1:0] r;
    mag  = v[AccW-1] ? AccW'(-v) : AccW'(v);
    half = {{(AccW-1){1'b0}}, 1'b1} << (s - 1);
    r    = (mag + half) >> s;
    return v[AccW-1] ? -$signed(r) : $signed(r);
  endfunction

endpackage

[hw/rtl/hps_if.sv]
// Channel interfaces for the head pose block: pose samples in, offsets out.
// No dependencies.
interface hps_in_if;
  logic               valid;
  logic               ready;
  logic [1:0]         func;
  logic signed [15:0] quat_north;
  logic signed [15:0] quat_west;
  logic signed [15:0] quat_up;
  logic signed [15:0] quat_scalar;
  modport source (output valid, func, quat_north, quat_west, quat_up, quat_scalar,
                  input ready);
  modport sink (input valid, func, quat_north, quat_west, quat_up, quat_scalar,
                output ready);
endinterface

interface hps_out_if;
  logic               valid;
  logic               ready;
  logic signed [23:0] offset_x;
  logic signed [23:0] offset_y;
  modport source (output valid, offset_x, offset_y, input ready);
  modport sink (input valid, offset_x, offset_y, output ready);
endinterface

[hw/rtl/head_pose_to_screen_offset.sv]
// Head pose to screen offset: quaternion relative rotation, projection, smoothing.
// A valid sample runs the relative rotation, projection and depth phases, then per axis the
// divide, target and filter phases; invalid, disable and recenter samples go straight to the
// output state. One sample at a time: the next is taken once the offset is registered, later
// while the output stalls. The multiplier is shared; the 16-step divider runs once per axis.
// Reset: asynchronous active low; control and config registers return to their defaults, no baseline.
// Depends on hps_pkg, hps_if, hps_mul, hps_div.
module head_pose_to_screen_offset (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [hps_pkg::CfgIdxW-1:0]    cfg_idx_i,
  input  logic [hps_pkg::CfgW-1:0]       cfg_data_i,
  hps_in_if.sink                         in_i,
  hps_out_if.source                      out_o
);
  import hps_pkg::*;

  // configuration
  logic [15:0] inv_htan_q, inv_vtan_q;
  logic [14:0] move_lim_q;
  logic [11:0] dead_band_q;
  logic [16:0] alpha_q;
  logic [19:0] max_step_q, half_w_q, half_h_q;

  // sequencer
  state_e state_q, state_d;
  phase_e ph_q, ph_d;
  logic [2:0] step_q, step_d;
  logic       axis_q, axis_d;

  // pose and filter state
  logic signed [15:0] qn_q, qw_q, qu_q, qs_q;
  logic signed [15:0] bn_q, bw_q, bu_q, bs_q;
  logic               base_vld_q, primed_q;
  logic signed [19:0] rx_q, ry_q, rz_q, rw_q;
  logic signed [40:0] vx_q, vy_q;
  logic [DenW-1:0]    dep_q;
  logic               vsgn_q;
  logic [14:0]        m_q;
  logic signed [23:0] tgt_q, sx_q, sy_q;
  logic signed [23:0] res_x_q, res_y_q;
  logic               ov_q;
  logic signed [23:0] ox_q, oy_q;

  logic signed [AccW-1:0] acc_q;

  // handshakes and step decode
  logic in_acc, out_free, consume, div_start, div_done;
  logic [2:0] k_muls;
  func_e func;

  assign func     = func_e'(in_i.func);
  assign in_acc   = in_i.valid && in_i.ready;
  assign out_free = !ov_q || out_o.ready;
  assign k_muls   = ph_muls(ph_q);
  assign consume  = (state_q == ST_MAC) && (step_q == k_muls + 3'd1);

  // multiplier operands
  logic signed [MulW-1:0] mul_a, mul_b;
  mul_ctl_t               mul_ctl, prod_ctl;
  logic signed [ProdW-1:0] prod;

  logic [40:0]        vmag;
  logic [15:0]        inv_sel;
  logic [19:0]        half_sel;
  logic signed [23:0] s_sel;
  logic signed [24:0] dlt;
  logic [16:0]        alpha_eff;
  logic signed [MulW-1:0] cs, cw, cu, cn;

  assign vmag      = axis_q ? (vy_q[40] ? 41'(-vy_q) : 41'(vy_q))
                            : (vx_q[40] ? 41'(-vx_q) : 41'(vx_q));
  assign inv_sel   = axis_q ? inv_vtan_q : inv_htan_q;
  assign half_sel  = axis_q ? half_h_q : half_w_q;
  assign s_sel     = axis_q ? sy_q : sx_q;
  assign dlt       = 25'(tgt_q) - 25'(s_sel);
  assign alpha_eff = (alpha_q > AlphaOne) ? AlphaOne : alpha_q;
  assign cs = MulW'(qs_q);
  assign cw = MulW'(qw_q);
  assign cu = MulW'(qu_q);
  assign cn = MulW'(qn_q);

  always_comb begin
    mul_a       = cs;
    mul_b       = MulW'(bs_q);
    mul_ctl     = '0;
    mul_ctl.vld = (state_q == ST_MAC) && (step_q < k_muls);
    mul_ctl.clr = (step_q == 3'd0);
    // current component runs S, W, U, N over the four steps of a quaternion sum
    case (step_q[1:0])
      2'd0:    mul_a = cs;
      2'd1:    mul_a = cw;
      2'd2:    mul_a = cu;
      default: mul_a = cn;
    endcase
    case (ph_q)
      PH_RX: begin
        case (step_q[1:0])
          2'd0:    begin mul_b = MulW'(bw_q); mul_ctl.neg = 1'b1; end
          2'd1:    mul_b = MulW'(bs_q);
          2'd2:    mul_b = MulW'(bn_q);
          default: begin mul_b = MulW'(bu_q); mul_ctl.neg = 1'b1; end
        endcase
      end
      PH_RY: begin
        case (step_q[1:0])
          2'd0:    mul_b = MulW'(bu_q);
          2'd1:    mul_b = MulW'(bn_q);
          2'd2:    begin mul_b = MulW'(bs_q); mul_ctl.neg = 1'b1; end
          default: begin mul_b = MulW'(bw_q); mul_ctl.neg = 1'b1; end
        endcase
      end
      PH_RZ: begin
        case (step_q[1:0])
          2'd0:    begin mul_b = MulW'(bn_q); mul_ctl.neg = 1'b1; end
          2'd1:    mul_b = MulW'(bu_q);
          2'd2:    begin mul_b = MulW'(bw_q); mul_ctl.neg = 1'b1; end
          default: mul_b = MulW'(bs_q);
        endcase
      end
      PH_RW: begin
        case (step_q[1:0])
          2'd0:    mul_b = MulW'(bs_q);
          2'd1:    mul_b = MulW'(bw_q);
          2'd2:    mul_b = MulW'(bu_q);
          default: mul_b = MulW'(bn_q);
        endcase
      end
      PH_VX: begin
        // -(rx*rz + rw*ry), doubled on the way out
        mul_ctl.neg = 1'b1;
        if (step_q[0]) begin
          mul_a = MulW'(rw_q); mul_b = MulW'(ry_q);
        end else begin
          mul_a = MulW'(rx_q); mul_b = MulW'(rz_q);
        end
      end
      PH_VY: begin
        if (step_q[0]) begin
          mul_a = MulW'(ry_q); mul_b = MulW'(rz_q); mul_ctl.neg = 1'b1;
        end else begin
          mul_a = MulW'(rw_q); mul_b = MulW'(rx_q);
        end
      end
      PH_DP: begin
        case (step_q[1:0])
          2'd0:    begin mul_a = MulW'(rw_q); mul_b = MulW'(rw_q); end
          2'd1:    begin mul_a = MulW'(rx_q); mul_b = MulW'(rx_q); mul_ctl.neg = 1'b1; end
          2'd2:    begin mul_a = MulW'(ry_q); mul_b = MulW'(ry_q); mul_ctl.neg = 1'b1; end
          default: begin mul_a = MulW'(rz_q); mul_b = MulW'(rz_q); end
        endcase
      end
      PH_NUM: begin
        // |v| * inv_tangent, with |v| split at bit 20 into a low and a high part
        mul_b = $signed({10'b0, inv_sel});
        if (step_q[0]) begin
          mul_a = $signed({5'b0, vmag[40:20]});
          mul_ctl.sh = 1'b1;
        end else begin
          mul_a = $signed({6'b0, vmag[19:0]});
        end
      end
      PH_TGT: begin
        mul_a = $signed({11'b0, m_q});
        mul_b = $signed({6'b0, half_sel});
      end
      PH_FLT: begin
        mul_a = MulW'(dlt);
        mul_b = $signed({9'b0, alpha_eff});
      end
      default: begin
        mul_a = cs;
      end
    endcase
  end

  hps_mul u_mul (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .a_i    (mul_a),
    .b_i    (mul_b),
    .ctl_i  (mul_ctl),
    .p_o    (prod),
    .ctl_o  (prod_ctl)
  );

  // accumulator
  logic signed [AccW-1:0] pext, term;
  assign pext = AccW'(prod);
  assign term = prod_ctl.sh ? (pext <<< 20) : pext;

  always_ff @(posedge clk_i) begin
    if (prod_ctl.vld) begin
      acc_q <= (prod_ctl.clr ? '0 : acc_q) + (prod_ctl.neg ? -term : term);
    end
  end

  // divider
  logic [QuoW-1:0] quo;
  assign div_start = consume && (ph_q == PH_NUM);

  hps_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (acc_q[NumW-1:0]),
    .den_i   (dep_q),
    .done_o  (div_done),
    .quo_o   (quo)
  );

  // clamp and deadzone on the quotient magnitude
  logic [15:0] qc;
  logic [14:0] m_new;
  assign qc    = (quo > {1'b0, move_lim_q}) ? {1'b0, move_lim_q} : quo;
  assign m_new = (qc < 16'(dead_band_q)) ? 15'd0 : 15'(qc - 16'(dead_band_q));

  // per-phase results
  logic signed [AccW-1:0] r14, r12, r16, stp, ms;
  logic signed [23:0]     tgt_new, s_new;
  assign r14 = rnd_shr(acc_q, 14);
  assign r12 = rnd_shr(acc_q, 12);
  assign r16 = rnd_shr(acc_q, 16);
  assign ms  = $signed({44'b0, max_step_q});
  assign stp = (r16 > ms) ? ms : ((r16 < -ms) ? -ms : r16);
  assign tgt_new = vsgn_q ? -24'(r12) : 24'(r12);
  assign s_new   = primed_q ? (s_sel + 24'(stp)) : tgt_q;

  // sequencer
  always_comb begin
    state_d = state_q;
    ph_d    = ph_q;
    step_d  = step_q;
    axis_d  = axis_q;
    case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          step_d = 3'd0;
          axis_d = 1'b0;
          ph_d   = PH_RX;
          state_d = (func == FUNC_VALID) ? ST_MAC : ST_OUT;
        end
      end
      ST_MAC: begin
        step_d = step_q + 3'd1;
        if (consume) begin
          step_d = 3'd0;
          case (ph_q)
            PH_RX:  ph_d = PH_RY;
            PH_RY:  ph_d = PH_RZ;
            PH_RZ:  ph_d = PH_RW;
            PH_RW:  ph_d = PH_VX;
            PH_VX:  ph_d = PH_VY;
            PH_VY:  ph_d = PH_DP;
            PH_DP:  ph_d = PH_NUM;
            PH_NUM: state_d = ST_DIV;
            PH_TGT: ph_d = PH_FLT;
            PH_FLT: begin
              if (axis_q) begin
                state_d = ST_OUT;
              end else begin
                axis_d = 1'b1;
                ph_d   = PH_NUM;
              end
            end
            default: ph_d = PH_RX;
          endcase
        end
      end
      ST_DIV: begin
        if (div_done) begin
          state_d = ST_MAC;
          ph_d    = PH_TGT;
          step_d  = 3'd0;
        end
      end
      ST_OUT: begin
        if (out_free) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      ph_q        <= PH_RX;
      step_q      <= 3'd0;
      axis_q      <= 1'b0;
      base_vld_q  <= 1'b0;
      primed_q    <= 1'b0;
      ov_q        <= 1'b0;
      inv_htan_q  <= 16'd4096;
      inv_vtan_q  <= 16'd4096;
      move_lim_q  <= 15'd24576;
      dead_band_q <= 12'd41;
      alpha_q     <= 17'd29491;
      max_step_q  <= 20'd10752;
      half_w_q    <= 20'd15360;
      half_h_q    <= 20'd8640;
    end else begin
      state_q <= state_d;
      ph_q    <= ph_d;
      step_q  <= step_d;
      axis_q  <= axis_d;
      if (cfg_we_i) begin
        case (reg_idx_e'(cfg_idx_i))
          REG_INV_HTAN:  inv_htan_q  <= cfg_data_i[15:0];
          REG_INV_VTAN:  inv_vtan_q  <= cfg_data_i[15:0];
          REG_MOVE_LIM:  move_lim_q  <= cfg_data_i[14:0];
          REG_DEAD_BAND: dead_band_q <= cfg_data_i[11:0];
          REG_ALPHA:     alpha_q     <= cfg_data_i[16:0];
          REG_MAX_STEP:  max_step_q  <= cfg_data_i;
          REG_HALF_W:    half_w_q    <= cfg_data_i;
          default:       half_h_q    <= cfg_data_i;
        endcase
      end
      if (in_acc) begin
        if (func == FUNC_VALID) begin
          base_vld_q <= 1'b1;
        end else if (func == FUNC_DISABLE || func == FUNC_RECENTER) begin
          base_vld_q <= 1'b0;
          primed_q   <= 1'b0;
        end
      end
      if (consume && ph_q == PH_FLT && axis_q) begin
        primed_q <= 1'b1;
      end
      if (state_q == ST_OUT && out_free) begin
        ov_q <= 1'b1;
      end else if (out_o.ready) begin
        ov_q <= 1'b0;
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      qn_q <= in_i.quat_north;
      qw_q <= in_i.quat_west;
      qu_q <= in_i.quat_up;
      qs_q <= in_i.quat_scalar;
      case (func)
        FUNC_VALID: begin
          // first valid sample after a clear becomes the baseline
          if (!base_vld_q) begin
            bn_q <= in_i.quat_north;
            bw_q <= in_i.quat_west;
            bu_q <= in_i.quat_up;
            bs_q <= in_i.quat_scalar;
          end
        end
        FUNC_INVALID: begin
          res_x_q <= primed_q ? sx_q : '0;
          res_y_q <= primed_q ? sy_q : '0;
        end
        default: begin
          sx_q    <= '0;
          sy_q    <= '0;
          res_x_q <= '0;
          res_y_q <= '0;
        end
      endcase
    end
    if (consume) begin
      case (ph_q)
        PH_RX:  rx_q <= 20'(r14);
        PH_RY:  ry_q <= 20'(r14);
        PH_RZ:  rz_q <= 20'(r14);
        PH_RW:  rw_q <= 20'(r14);
        PH_VX:  vx_q <= {acc_q[39:0], 1'b0};
        PH_VY:  vy_q <= {acc_q[39:0], 1'b0};
        PH_DP:  dep_q <= (acc_q < DepthFloor) ? DenW'(DepthFloor) : acc_q[DenW-1:0];
        PH_NUM: vsgn_q <= axis_q ? vy_q[40] : vx_q[40];
        PH_TGT: tgt_q <= tgt_new;
        PH_FLT: begin
          if (axis_q) begin
            sy_q    <= s_new;
            res_x_q <= sx_q;
            res_y_q <= s_new;
          end else begin
            sx_q <= s_new;
          end
        end
        default: begin
          tgt_q <= tgt_q;
        end
      endcase
    end
    if (div_done) begin
      m_q <= m_new;
    end
    if (state_q == ST_OUT && out_free) begin
      ox_q <= res_x_q;
      oy_q <= res_y_q;
    end
  end

  assign in_i.ready     = (state_q == ST_IDLE);
  assign out_o.valid    = ov_q;
  assign out_o.offset_x = ox_q;
  assign out_o.offset_y = oy_q;
endmodule

[hw/rtl/hps_mul.sv]
// Shared signed multiplier with registered product and command side-band.
// Depends on hps_pkg.
module hps_mul (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic signed [hps_pkg::MulW-1:0]  a_i,
  input  logic signed [hps_pkg::MulW-1:0]  b_i,
  input  hps_pkg::mul_ctl_t                ctl_i,
  output logic signed [hps_pkg::ProdW-1:0] p_o,
  output hps_pkg::mul_ctl_t                ctl_o
);
  import hps_pkg::*;

  logic signed [ProdW-1:0] p_q;
  mul_ctl_t                ctl_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctl_q <= '0;
    end else begin
      ctl_q <= ctl_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.vld) begin
      p_q <= a_i * b_i;
    end
  end

  assign p_o   = p_q;
  assign ctl_o = ctl_q;
endmodule

[hw/rtl/hps_div.sv]
// Restoring divider, one quotient bit a cycle, 16 bits with saturation flag.
// Depends on hps_pkg.
module hps_div (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start_i,
  input  logic [hps_pkg::NumW-1:0]    num_i,
  input  logic [hps_pkg::DenW-1:0]    den_i,
  output logic                        done_o,
  output logic [hps_pkg::QuoW-1:0]    quo_o
);
  import hps_pkg::*;

  logic            run_q, done_q;
  logic [3:0]      cnt_q;
  logic [NumW-1:0] rem_q, dsh_q;
  logic [QuoW-1:0] quo_q;
  logic            sat_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      done_q <= 1'b0;
    end else begin
      done_q <= run_q && (cnt_q == 4'd0);
      if (start_i) begin
        run_q <= 1'b1;
      end else if (run_q && (cnt_q == 4'd0)) begin
        run_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= num_i;
      dsh_q <= NumW'(den_i) << 15;
      cnt_q <= 4'd15;
      quo_q <= '0;
      sat_q <= 1'b0;
    end else if (run_q) begin
      if (rem_q >= dsh_q) begin
        rem_q        <= rem_q - dsh_q;
        quo_q[cnt_q] <= 1'b1;
        // top bit set: quotient is past any movement limit
        if (cnt_q == 4'd15) begin
          sat_q <= 1'b1;
        end
      end
      dsh_q <= dsh_q >> 1;
      cnt_q <= cnt_q - 4'd1;
    end
  end

  assign done_o = done_q;
  assign quo_o  = sat_q ? 16'h8000 : quo_q;
endmodule

[hw/rtl/hps_chk.sv]
// Port-level checker for the head pose block, bound to the top level.
// Depends on hps_pkg and head_pose_to_screen_offset_macros.svh.
`include "head_pose_to_screen_offset_macros.svh"

module hps_chk (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               in_valid_i,
  input logic               in_ready_i,
  input logic [1:0]         in_func_i,
  input logic               out_valid_i,
  input logic               out_ready_i,
  input logic signed [23:0] offset_x_i,
  input logic signed [23:0] offset_y_i
);
  import hps_pkg::*;

  logic in_acc;
  assign in_acc = in_valid_i && in_ready_i;

  // a held result stays put until taken
  `HPS_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_valid_i && !out_ready_i, out_valid_i && $stable(offset_x_i) && $stable(offset_y_i))

  // one sample at a time
  `HPS_ASSERT_NEXT(a_busy_after_accept, clk_i, rst_ni, in_acc, !in_ready_i)

  // a disable or recenter with a free output gives a zero offset once through the output state
  `HPS_ASSERT_NEXT(a_clear_zero, clk_i, rst_ni, in_acc && !out_valid_i && (in_func_i == FUNC_DISABLE || in_func_i == FUNC_RECENTER), ##1 (out_valid_i && offset_x_i == 24'sd0 && offset_y_i == 24'sd0))

endmodule

bind head_pose_to_screen_offset hps_chk u_hps_chk (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_i.valid),
  .in_ready_i  (in_i.ready),
  .in_func_i   (in_i.func),
  .out_valid_i (out_o.valid),
  .out_ready_i (out_o.ready),
  .offset_x_i  (out_o.offset_x),
  .offset_y_i  (out_o.offset_y)
);

[verif/tb_head_pose_to_screen_offset.sv]
// Testbench for head_pose_to_screen_offset: drives pose samples and config writes,
// predicts offsets with a bit-exact model and checks every output transaction.
// Depends on hps_pkg, hps_if and the block RTL.
module tb_head_pose_to_screen_offset;
  timeunit 1ns;
  timeprecision 1ps;
  import hps_pkg::*;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we_i = 1'b0;
  logic [CfgIdxW-1:0] cfg_idx_i = '0;
  logic [CfgW-1:0] cfg_data_i = '0;

  hps_in_if  pose_ch ();
  hps_out_if offs_ch ();

  head_pose_to_screen_offset u_top (
    .clk_i(clk_i), .rst_ni(rst_ni), .cfg_we_i(cfg_we_i), .cfg_idx_i(cfg_idx_i),
    .cfg_data_i(cfg_data_i), .in_i(pose_ch.sink), .out_o(offs_ch.source)
  );

  always #2 clk_i = ~clk_i;

  // predictor copy of config and state
  longint p_ihtan, p_ivtan, p_lim, p_dz, p_alpha, p_mstep, p_hw, p_hh;
  bit p_base_ok, p_primed;
  longint p_base[4];
  longint p_smooth[2];

  typedef struct {
    logic [23:0] x;
    logic [23:0] y;
  } offset_t;
  offset_t offset_q[$];

  int errors = 0;
  longint cycles = 0;
  bit quiet = 1'b0;   // no idling in the final stretch
  int out_stall = 0;

  function automatic longint rnd_sh(longint v, int s);
    longint h;
    h = longint'(1) << (s - 1);
    if (v < 0) return -((-v + h) >>> s);
    return (v + h) >>> s;
  endfunction

  function automatic longint clampl(longint v, longint lo, longint hi);
    return v < lo ? lo : (v > hi ? hi : v);
  endfunction

  function automatic void clear_pose();
    p_base_ok = 0; p_primed = 0;
    p_base[0] = 0; p_base[1] = 0; p_base[2] = 0; p_base[3] = 16384;
    p_smooth[0] = 0; p_smooth[1] = 0;
  endfunction

  function automatic void defaults();
    p_ihtan = 4096; p_ivtan = 4096; p_lim = 24576; p_dz = 41;
    p_alpha = 29491; p_mstep = 10752; p_hw = 15360; p_hh = 8640;
    clear_pose();
  endfunction

  function automatic longint axis_px(longint comp, longint depth, longint itan,
                                     longint half);
    longint n;
    n = (comp * itan) / depth;  // truncates toward zero
    n = clampl(n, -p_lim, p_lim);
    if ((n < 0 ? -n : n) < p_dz) n = 0;
    else if (n > 0) n -= p_dz;
    else n += p_dz;
    return rnd_sh(n * half, 12);
  endfunction

  // compute next offset for one accepted pose transaction
  function automatic offset_t predict_offset(logic [1:0] fn, logic signed [15:0] qn,
      logic signed [15:0] qw, logic signed [15:0] qu, logic signed [15:0] qs);
    offset_t o;
    longint bx, by, bz, bw, ax, ay, az, aw, rx, ry, rz, rw, vx, vy, depth, al;
    longint t[2];
    longint s, f;
    o.x = '0; o.y = '0;
    if (fn == FUNC_DISABLE || fn == FUNC_RECENTER) begin
      clear_pose();
    end else if (fn == FUNC_INVALID) begin
      if (p_primed) begin
        o.x = p_smooth[0][23:0]; o.y = p_smooth[1][23:0];
      end
    end else begin
      al = p_alpha > 65536 ? 65536 : p_alpha;
      if (!p_base_ok) begin
        p_base_ok = 1;
        p_base[0] = qn; p_base[1] = qw; p_base[2] = qu; p_base[3] = qs;
      end
      // conj(current) with current = (-w, u, -n, s)
      ax = qw; ay = -longint'(qu); az = qn; aw = qs;
      bx = -p_base[1]; by = p_base[2]; bz = -p_base[0]; bw = p_base[3];
      rx = rnd_sh(aw*bx + ax*bw + ay*bz - az*by, 14);
      ry = rnd_sh(aw*by - ax*bz + ay*bw + az*bx, 14);
      rz = rnd_sh(aw*bz + ax*by - ay*bx + az*bw, 14);
      rw = rnd_sh(aw*bw - ax*bx - ay*by - az*bz, 14);
      vx = -2 * (rx*rz + rw*ry);
      vy = 2 * (rw*rx - ry*rz);
      depth = rw*rw - rx*rx - ry*ry + rz*rz;
      if (depth < 268435) depth = 268435;
      t[0] = axis_px(vx, depth, p_ihtan, p_hw);
      t[1] = axis_px(vy, depth, p_ivtan, p_hh);
      if (!p_primed) begin
        p_primed = 1;
        p_smooth[0] = t[0]; p_smooth[1] = t[1];
      end else begin
        for (int i = 0; i < 2; i++) begin
          s = p_smooth[i];
          f = s + rnd_sh((t[i] - s) * al, 16);
          p_smooth[i] = s + clampl(f - s, -p_mstep, p_mstep);
        end
      end
      o.x = p_smooth[0][23:0]; o.y = p_smooth[1][23:0];
    end
    return o;
  endfunction

  // directed table; has_exp marks rows whose result is obvious by eye
  typedef struct {
    logic [1:0] fn;
    logic signed [15:0] n, w, u, s;
    bit has_exp;
    logic [23:0] ex, ey;
  } row_t;
  row_t dir_tab[$];

  task automatic cfg_write(reg_idx_e idx, logic [CfgW-1:0] val);
    cfg_we_i <= 1'b1; cfg_idx_i <= idx; cfg_data_i <= val;
    @(posedge clk_i);
    case (idx)
      REG_INV_HTAN:  p_ihtan = val[15:0];
      REG_INV_VTAN:  p_ivtan = val[15:0];
      REG_MOVE_LIM:  p_lim = val[14:0];
      REG_DEAD_BAND: p_dz = val[11:0];
      REG_ALPHA:     p_alpha = val[16:0];
      REG_MAX_STEP:  p_mstep = val[19:0];
      REG_HALF_W:    p_hw = val[19:0];
      default:       p_hh = val[19:0];
    endcase
  endtask

  // wait for all outputs, then let the block settle before touching registers
  task automatic drain();
    pose_ch.valid <= 1'b0;
    while (offset_q.size() != 0) @(posedge clk_i);
    repeat (120) @(posedge clk_i);
  endtask

  task automatic send_pose(row_t r);
    offset_t e;
    if (!quiet && $urandom_range(0, 3) == 0) begin
      pose_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 16)) @(posedge clk_i);
    end
    pose_ch.valid <= 1'b1;
    pose_ch.func <= r.fn;
    pose_ch.quat_north <= r.n; pose_ch.quat_west <= r.w;
    pose_ch.quat_up <= r.u; pose_ch.quat_scalar <= r.s;
    @(posedge clk_i);
    while (!pose_ch.ready) @(posedge clk_i);
    e = predict_offset(r.fn, r.n, r.w, r.u, r.s);
    if (r.has_exp && (e.x != r.ex || e.y != r.ey))
      $display("%0t: table row disagrees with predictor", $time);
    if (r.has_exp) begin
      e.x = r.ex; e.y = r.ey;
    end
    offset_q.push_back(e);
  endtask

  function automatic row_t mk(logic [1:0] fn, int n, int w, int u, int s,
                              bit he = 0, int ex = 0, int ey = 0);
    row_t r;
    r.fn = fn; r.n = 16'(n); r.w = 16'(w); r.u = 16'(u); r.s = 16'(s);
    r.has_exp = he; r.ex = 24'(ex); r.ey = 24'(ey);
    return r;
  endfunction

  // small rotation around identity, mostly well formed
  function automatic int jitter(int span);
    return $urandom_range(0, 2*span) - span;
  endfunction

  function automatic row_t rand_row();
    row_t r;
    int k;
    int span;
    k = $urandom_range(0, 99);
    span = ($urandom_range(0, 3) == 0) ? 8000 : 1500;
    if (k < 70) r = mk(FUNC_VALID, jitter(span), jitter(span), jitter(span),
                       16384 - $urandom_range(0, span));
    else if (k < 78) r = mk(FUNC_VALID, $urandom, $urandom, $urandom, $urandom);
    else if (k < 90) r = mk(FUNC_INVALID, $urandom, $urandom, $urandom, $urandom);
    else if (k < 95) r = mk(FUNC_RECENTER, $urandom, $urandom, $urandom, $urandom);
    else r = mk(FUNC_DISABLE, $urandom, $urandom, $urandom, $urandom);
    return r;
  endfunction

  // output side: random stall bursts and checking
  always @(posedge clk_i) begin
    offset_t e;
    cycles <= cycles + 1;
    if (rst_ni) begin
      if (offs_ch.valid && offs_ch.ready) begin
        if (offset_q.size() == 0) begin
          $display("%0t: unexpected offset x=%0d y=%0d", $time,
                   offs_ch.offset_x, offs_ch.offset_y);
          errors++;
        end else begin
          e = offset_q.pop_front();
          if (offs_ch.offset_x !== e.x) begin
            $display("%0t: offset_x expected %0d actual %0d", $time,
                     $signed(e.x), offs_ch.offset_x);
            errors++;
          end
          if (offs_ch.offset_y !== e.y) begin
            $display("%0t: offset_y expected %0d actual %0d", $time,
                     $signed(e.y), offs_ch.offset_y);
            errors++;
          end
        end
      end
      if (out_stall > 0) begin
        out_stall <= out_stall - 1;
        offs_ch.ready <= (out_stall == 1);
      end else if (!quiet && $urandom_range(0, 7) == 0) begin
        out_stall <= $urandom_range(1, 16);
        offs_ch.ready <= 1'b0;
      end else begin
        offs_ch.ready <= 1'b1;
      end
    end
  end

  // watchdog
  always @(posedge clk_i) begin
    if (cycles > 3000000) begin
      $display("tb_head_pose_to_screen_offset: done, errors");
      $finish;
    end
  end

  initial begin
    int n_rand;
    pose_ch.valid = 1'b0; pose_ch.func = FUNC_VALID;
    pose_ch.quat_north = '0; pose_ch.quat_west = '0;
    pose_ch.quat_up = '0; pose_ch.quat_scalar = '0;
    offs_ch.ready = 1'b0;
    defaults();
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: invalid before priming, first valid, extremes, clears
    dir_tab.push_back(mk(FUNC_INVALID, 16384, -16384, 16384, -16384, 1, 0, 0));
    dir_tab.push_back(mk(FUNC_VALID, 0, 0, 0, 16384, 1, 0, 0));      // baseline = identity
    dir_tab.push_back(mk(FUNC_VALID, 2000, -1500, 800, 16000));
    dir_tab.push_back(mk(FUNC_INVALID, 0, 0, 0, 0));                // held offset
    dir_tab.push_back(mk(FUNC_VALID, 16384, 16384, 16384, 16384));
    dir_tab.push_back(mk(FUNC_VALID, -16384, -16384, -16384, -16384));
    dir_tab.push_back(mk(FUNC_VALID, 0, 0, 16384, 0));              // depth floor
    dir_tab.push_back(mk(FUNC_VALID, -32768, 32767, -32768, 32767)); // out of range
    dir_tab.push_back(mk(FUNC_DISABLE, 1, 2, 3, 4, 1, 0, 0));
    dir_tab.push_back(mk(FUNC_INVALID, 5, 5, 5, 5, 1, 0, 0));
    dir_tab.push_back(mk(FUNC_VALID, 3000, 3000, -3000, 15000));     // new baseline
    dir_tab.push_back(mk(FUNC_VALID, 3000, 3000, -3000, 15000));
    dir_tab.push_back(mk(FUNC_VALID, -4000, 1000, 2000, 15500));
    dir_tab.push_back(mk(FUNC_RECENTER, 0, 0, 0, 0, 1, 0, 0));
    dir_tab.push_back(mk(FUNC_VALID, 100, -100, 100, 16380));
    dir_tab.push_back(mk(FUNC_VALID, -6000, 5000, -4000, 13000));
    foreach (dir_tab[i]) send_pose(dir_tab[i]);
    drain();

    // phases of random traffic across register settings, extremes included
    for (int ph = 0; ph < 8; ph++) begin
      case (ph)
        0: begin end  // reset values
        1: begin
          cfg_write(REG_INV_HTAN, CfgW'(16'hFFFF)); cfg_write(REG_INV_VTAN, CfgW'(16'hFFFF));
          cfg_write(REG_MOVE_LIM, CfgW'(15'h7FFF)); cfg_write(REG_DEAD_BAND, CfgW'(12'd0));
          cfg_write(REG_ALPHA, CfgW'(17'h1FFFF)); cfg_write(REG_MAX_STEP, 20'hFFFFF);
          cfg_write(REG_HALF_W, 20'hFFFFF); cfg_write(REG_HALF_H, 20'hFFFFF);
        end
        2: begin
          cfg_write(REG_INV_HTAN, CfgW'(16'd0)); cfg_write(REG_INV_VTAN, CfgW'(16'd0));
          cfg_write(REG_MOVE_LIM, CfgW'(15'd0)); cfg_write(REG_DEAD_BAND, CfgW'(12'hFFF));
          cfg_write(REG_ALPHA, CfgW'(17'd0)); cfg_write(REG_MAX_STEP, 20'd0);
          cfg_write(REG_HALF_W, 20'd0); cfg_write(REG_HALF_H, 20'd0);
        end
        default: begin
          cfg_write(REG_INV_HTAN, CfgW'($urandom)); cfg_write(REG_INV_VTAN, CfgW'($urandom));
          cfg_write(REG_MOVE_LIM, CfgW'($urandom));
          cfg_write(REG_DEAD_BAND, CfgW'($urandom_range(0, 300)));
          cfg_write(REG_ALPHA, CfgW'($urandom_range(0, 70000)));
          cfg_write(REG_MAX_STEP, CfgW'($urandom));
          cfg_write(REG_HALF_W, CfgW'($urandom)); cfg_write(REG_HALF_H, CfgW'($urandom));
        end
      endcase
      cfg_we_i <= 1'b0;
      n_rand = 244;
      if (ph == 7) quiet = 1'b1;
      for (int k = 0; k < n_rand; k++) send_pose(rand_row());
      drain();
    end

    repeat (200) @(posedge clk_i);
    if (errors == 0 && offset_q.size() == 0) begin
      $display("tb_head_pose_to_screen_offset: done, clean");
    end else begin
      $display("tb_head_pose_to_screen_offset: done, errors");
    end
    $finish;
  end
endmodule
